>>> src/assert_macros.svh
// assertion macros shared by the step generator modules
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(name, clk, rst_n, pre, post)
`define ASSERT_NXT(name, clk, rst_n, pre, post)
`endif
`endif

>>> src/srsg_pkg.sv
// shared constants, register indexes and control structs of the step generator
// no dependencies
`timescale 1ns / 1ps

package srsg_pkg;

    localparam int TIME_BASE_US_DEF = 1000000;
    localparam int SPEED_WIDTH_DEF  = 16;
    localparam int TIME_WIDTH_DEF   = 32;

    localparam int ACCEL_W    = 20;
    localparam int MAXSPD_W   = 16;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int INTERVAL_W = 20;
    localparam int MOTION_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EN_POL    = 2'd2;

    localparam logic [ACCEL_W-1:0]  ACCEL_RST     = 20'd10000;
    localparam logic [MAXSPD_W-1:0] MAX_SPEED_RST = 16'd4000;
    localparam logic                EN_POL_RST    = 1'b1;

    localparam logic [MOTION_W-1:0] MOTION_STOPPED = 2'd0;
    localparam logic [MOTION_W-1:0] MOTION_FWD     = 2'd1;
    localparam logic [MOTION_W-1:0] MOTION_REV     = 2'd2;

    // accel / 1000 as multiply by ceil(2^30 / 1000), exact for 20-bit accel
    localparam int                 RECIP_W     = 21;
    localparam int                 RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP_1000  = 21'd1073742;
    localparam int                 LIM_W       = 11;

    typedef struct packed {
        logic load;
        logic calc;
        logic ramp;
        logic div_start;
        logic finish;
    } srsg_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_last;
    } srsg_sts_t;

endpackage

>>> src/srsg_if.sv
// request channels of the step generator: control tick in, pin/status result out
// depends on srsg_pkg
`timescale 1ns / 1ps

interface srsg_in_if
    import srsg_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   run_enable;
    logic                   go_forward;
    logic [SPEED_WIDTH-1:0] target_speed;
    logic [TIME_WIDTH-1:0]  now_us;

    modport source (output valid, run_enable, go_forward, target_speed, now_us, input ready);
    modport sink   (input valid, run_enable, go_forward, target_speed, now_us, output ready);
endinterface

interface srsg_out_if
    import srsg_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   step_pulse;
    logic                   direction_level;
    logic                   driver_enable_level;
    logic [MOTION_W-1:0]    motion_state;
    logic [SPEED_WIDTH-1:0] speed_now;
    logic [INTERVAL_W-1:0]  interval_us;

    modport source (output valid, step_pulse, direction_level, driver_enable_level,
                    motion_state, speed_now, interval_us, input ready);
    modport sink   (input valid, step_pulse, direction_level, driver_enable_level,
                    motion_state, speed_now, interval_us, output ready);
endinterface

>>> src/stepper_ramp_step_generator.sv
// top level of the stepper trapezoidal ramp step generator
// depends on srsg_pkg, srsg_if, srsg_ctrl and srsg_datapath
`timescale 1ns / 1ps

// One request on tick is one control tick: the target speed is clamped to max_speed, the
// current speed ramps toward it by max(accel/1000, 1) (or drops to zero when run_enable is
// low), the step interval is TIME_BASE_US divided by that speed, and a step is flagged once
// the wrapped time since the last step reaches the interval. The bit-serial divider produces
// one quotient bit per cycle over NUM_W = clog2(TIME_BASE_US + 1) bits; the result request
// sits in an output register, so the next tick is taken while it waits, and a tick waits in
// finish until the previous result is taken. Configuration writes land directly in the
// config registers; no reset sweep is needed.
module stepper_ramp_step_generator
    import srsg_pkg::*;
#(
    parameter int TIME_BASE_US = TIME_BASE_US_DEF,
    parameter int SPEED_WIDTH  = SPEED_WIDTH_DEF,
    parameter int TIME_WIDTH   = TIME_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    srsg_in_if.sink               tick,
    srsg_out_if.source            result
);

    srsg_cmd_t cmd;
    srsg_sts_t sts;

    srsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tick.valid),
        .in_ready  (tick.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    srsg_datapath #(
        .TIME_BASE_US (TIME_BASE_US),
        .SPEED_WIDTH  (SPEED_WIDTH),
        .TIME_WIDTH   (TIME_WIDTH)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .cmd                 (cmd),
        .sts                 (sts),
        .run_enable          (tick.run_enable),
        .go_forward          (tick.go_forward),
        .target_speed        (tick.target_speed),
        .now_us              (tick.now_us),
        .step_pulse          (result.step_pulse),
        .direction_level     (result.direction_level),
        .driver_enable_level (result.driver_enable_level),
        .motion_state        (result.motion_state),
        .speed_now           (result.speed_now),
        .interval_us         (result.interval_us)
    );

endmodule

>>> src/srsg_div.sv
// restoring divider of a constant dividend by the speed, one quotient bit per cycle
// depends on srsg_pkg
`timescale 1ns / 1ps

module srsg_div
    import srsg_pkg::*;
#(
    parameter int DIVIDEND = TIME_BASE_US_DEF,
    parameter int NUM_W    = 20,
    parameter int DEN_W    = SPEED_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DEN_W-1:0] divisor,
    output logic             busy,
    output logic             last,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};
    assign last  = busy_reg && (cnt_reg == CNT_W'(NUM_W - 1));

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = NUM_W'(DIVIDEND);
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[NUM_W-2:0], ge};
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

>>> src/srsg_datapath.sv
// datapath: config registers, clamp and ramp, step timing, motion state, result register
// depends on srsg_pkg, srsg_div and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srsg_datapath
    import srsg_pkg::*;
#(
    parameter int TIME_BASE_US = TIME_BASE_US_DEF,
    parameter int SPEED_WIDTH  = SPEED_WIDTH_DEF,
    parameter int TIME_WIDTH   = TIME_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  srsg_cmd_t              cmd,
    output srsg_sts_t              sts,
    input  logic                   run_enable,
    input  logic                   go_forward,
    input  logic [SPEED_WIDTH-1:0] target_speed,
    input  logic [TIME_WIDTH-1:0]  now_us,
    output logic                   step_pulse,
    output logic                   direction_level,
    output logic                   driver_enable_level,
    output logic [MOTION_W-1:0]    motion_state,
    output logic [SPEED_WIDTH-1:0] speed_now,
    output logic [INTERVAL_W-1:0]  interval_us
);

    localparam int NUM_W  = $clog2(TIME_BASE_US + 1);
    localparam int CW     = (SPEED_WIDTH > MAXSPD_W) ? SPEED_WIDTH : MAXSPD_W;
    localparam int RW     = (CW > LIM_W) ? CW : LIM_W;
    localparam int CMP_W  = (TIME_WIDTH > NUM_W) ? TIME_WIDTH : NUM_W;
    localparam int QX_W   = (NUM_W > INTERVAL_W) ? NUM_W : INTERVAL_W;
    localparam int PROD_W = ACCEL_W + RECIP_W;

    // configuration
    logic [ACCEL_W-1:0]  accel_reg;
    logic [MAXSPD_W-1:0] max_speed_reg;
    logic                en_pol_reg;

    // captured tick
    logic                   en_reg;
    logic                   fwd_reg;
    logic [SPEED_WIDTH-1:0] tgt_reg;
    logic [TIME_WIDTH-1:0]  now_reg;

    // per-tick intermediates
    logic [CW-1:0]          tgt_c_reg, tgt_c_next;
    logic [LIM_W-1:0]       lim_reg, lim_next;
    logic [SPEED_WIDTH-1:0] spd_new_reg, spd_new_next;

    // block state
    logic [SPEED_WIDTH-1:0] ramp_speed_reg;
    logic [TIME_WIDTH-1:0]  last_step_reg;
    logic [MOTION_W-1:0]    motion_reg, motion_next;

    // result register
    logic                   res_step_reg;
    logic                   res_dir_reg;
    logic                   res_drv_reg;
    logic [MOTION_W-1:0]    res_motion_reg;
    logic [SPEED_WIDTH-1:0] res_speed_reg;
    logic [INTERVAL_W-1:0]  res_interval_reg;

    logic [PROD_W-1:0]     prod;
    logic [LIM_W-1:0]      lim_raw;
    logic [CW-1:0]         tgt_x, max_x;
    logic [RW-1:0]         cur_r, tgt_r, lim_r, ramp_r;
    logic [NUM_W-1:0]      quot;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  step_c;
    logic [QX_W-1:0]       quot_x;
    logic [INTERVAL_W-1:0] interval_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg     <= ACCEL_RST;
            max_speed_reg <= MAX_SPEED_RST;
            en_pol_reg    <= EN_POL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACCEL:     accel_reg     <= cfg_data[ACCEL_W-1:0];
                REG_MAX_SPEED: max_speed_reg <= cfg_data[MAXSPD_W-1:0];
                REG_EN_POL:    en_pol_reg    <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // clamp and per-tick limit
    assign prod    = PROD_W'(accel_reg) * PROD_W'(RECIP_1000);
    assign lim_raw = prod[RECIP_SHIFT +: LIM_W];
    assign tgt_x   = CW'(tgt_reg);
    assign max_x   = CW'(max_speed_reg);

    always_comb
    begin
        tgt_c_next = (tgt_x > max_x) ? max_x : tgt_x;
        lim_next   = (lim_raw == '0) ? LIM_W'(1) : lim_raw;
    end

    // move toward the target by at most lim
    assign cur_r = RW'(ramp_speed_reg);
    assign tgt_r = RW'(tgt_c_reg);
    assign lim_r = RW'(lim_reg);

    always_comb
    begin
        if (tgt_r > cur_r)
        begin
            ramp_r = ((tgt_r - cur_r) > lim_r) ? (cur_r + lim_r) : tgt_r;
        end
        else if (cur_r > tgt_r)
        begin
            ramp_r = ((cur_r - tgt_r) > lim_r) ? (cur_r - lim_r) : tgt_r;
        end
        else
        begin
            ramp_r = cur_r;
        end
        spd_new_next = en_reg ? ramp_r[SPEED_WIDTH-1:0] : '0;
    end

    srsg_div #(
        .DIVIDEND (TIME_BASE_US),
        .NUM_W    (NUM_W),
        .DEN_W    (SPEED_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .divisor  (spd_new_next),
        .busy     (sts.div_busy),
        .last     (sts.div_last),
        .quotient (quot)
    );

    // step decision on the full quotient
    assign elapsed = now_reg - last_step_reg;
    assign step_c  = (spd_new_reg != '0) && (quot != '0)
                     && (CMP_W'(elapsed) >= CMP_W'(quot));
    assign quot_x  = QX_W'(quot);
    assign interval_c = (spd_new_reg != '0) ? quot_x[INTERVAL_W-1:0] : '0;

    always_comb
    begin
        motion_next = motion_reg;
        if (!en_reg)
        begin
            motion_next = MOTION_STOPPED;
        end
        else if (step_c || (motion_reg != MOTION_STOPPED))
        begin
            motion_next = fwd_reg ? MOTION_FWD : MOTION_REV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg        <= 1'b1;
            ramp_speed_reg <= '0;
            last_step_reg  <= '0;
            motion_reg     <= MOTION_STOPPED;
        end
        else
        begin
            if (cmd.load)
            begin
                fwd_reg <= go_forward;
            end
            if (cmd.finish)
            begin
                ramp_speed_reg <= spd_new_reg;
                motion_reg     <= motion_next;
                if (step_c)
                begin
                    last_step_reg <= now_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            en_reg  <= run_enable;
            tgt_reg <= target_speed;
            now_reg <= now_us;
        end
        if (cmd.calc)
        begin
            tgt_c_reg <= tgt_c_next;
            lim_reg   <= lim_next;
        end
        if (cmd.ramp)
        begin
            spd_new_reg <= spd_new_next;
        end
        if (cmd.finish)
        begin
            res_step_reg     <= step_c;
            res_dir_reg      <= fwd_reg;
            res_drv_reg      <= en_pol_reg ? ~en_reg : en_reg;
            res_motion_reg   <= motion_next;
            res_speed_reg    <= spd_new_reg;
            res_interval_reg <= interval_c;
        end
    end

    assign step_pulse          = res_step_reg;
    assign direction_level     = res_dir_reg;
    assign driver_enable_level = res_drv_reg;
    assign motion_state        = res_motion_reg;
    assign speed_now           = res_speed_reg;
    assign interval_us         = res_interval_reg;

    `ASSERT_NXT(a_step_stamps_time, clk, rst_n, cmd.finish && step_c, last_step_reg == $past(now_reg))
    `ASSERT_NXT(a_disable_clears, clk, rst_n, cmd.finish && !en_reg, (motion_reg == MOTION_STOPPED) && (ramp_speed_reg == '0))

endmodule

>>> src/srsg_ctrl.sv
// controller: sequences capture, clamp, ramp, divide and finish; owns the result valid
// depends on srsg_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srsg_ctrl
    import srsg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output srsg_cmd_t cmd,
    input  srsg_sts_t sts
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CALC   = 3'd1;
    localparam logic [2:0] ST_RAMP   = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    // the result register can take a new result once the old one is gone
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_RAMP;
            end
            ST_RAMP:
            begin
                cmd.ramp      = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && !out_ready) || cmd.finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `ASSERT_IMP(a_div_runs_in_div, clk, rst_n, state_reg == ST_DIV, sts.div_busy)
    `ASSERT_IMP(a_no_accept_while_dividing, clk, rst_n, sts.div_busy, !in_ready)
    `ASSERT_NXT(a_finish_shows_result, clk, rst_n, cmd.finish, out_valid_reg && (state_reg == ST_IDLE))

endmodule
